>>> rtl/ccle_pkg.sv
package ccle_pkg;

  // Cluster and log geometry
  localparam int NODES     = 16;
  localparam int LOG_DEPTH = 1024;
  localparam int TERM_W    = 24;

  localparam int NODE_W  = $clog2(NODES);
  localparam int CNT_W   = $clog2(NODES + 1);
  localparam int POS_W   = $clog2(LOG_DEPTH);
  localparam int FILL_W  = $clog2(LOG_DEPTH + 1);
  localparam int LOG_AW  = NODE_W + POS_W;
  localparam int PEER_AW = 2 * NODE_W;

  localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
  localparam logic [CNT_W-1:0]  NO_NODE  = CNT_W'(NODES);

  // Node roles
  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  // Operation codes
  localparam logic [1:0] OP_ELECT  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;
  localparam logic [1:0] OP_APPLY  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOLEADER = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic              cmd;
    logic [31:0]       token;
  } slot_word_t;

  typedef struct packed {
    logic [FILL_W-1:0] next;
    logic [FILL_W-1:0] match;
  } peer_entry_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              elected;
    logic [CNT_W-1:0]  vote_total;
    logic [POS_W-1:0]  entry_index;
    logic [FILL_W-1:0] commit_point;
    logic [FILL_W-1:0] applied_point;
    logic [31:0]       machine_count;
    logic [31:0]       last_applied_command;
    logic [CNT_W-1:0]  leader_node;
  } res_t;

endpackage

>>> rtl/ccle_ram.sv
module ccle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ccle_ctrl.sv
module ccle_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      init,
  input  logic [ccle_pkg::CNT_W-1:0] cs,
  input  logic                      start,
  input  logic [1:0]                op,
  input  logic [ccle_pkg::NODE_W-1:0] node,
  input  logic [31:0]               token,
  input  logic                      out_hold,
  output logic                      idle,
  output logic                      done,
  output ccle_pkg::res_t            res
);
  import ccle_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_EL_PR  = 4'd2;
  localparam logic [3:0] S_EL_ROW = 4'd3;
  localparam logic [3:0] S_AP_PRD = 4'd4;
  localparam logic [3:0] S_AP_PWT = 4'd5;
  localparam logic [3:0] S_AP_CRD = 4'd6;
  localparam logic [3:0] S_AP_CWR = 4'd7;
  localparam logic [3:0] S_AP_PWR = 4'd8;
  localparam logic [3:0] S_CM_GRD = 4'd9;
  localparam logic [3:0] S_CM_GWT = 4'd10;
  localparam logic [3:0] S_CM_RD  = 4'd11;
  localparam logic [3:0] S_CM_CHK = 4'd12;
  localparam logic [3:0] S_AY_RD  = 4'd13;
  localparam logic [3:0] S_AY_UPD = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  localparam logic [CNT_W-1:0]  LAST_PEER = CNT_W'(NODES - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(LOG_DEPTH);

  // Per-node state
  logic [1:0]        role_a    [NODES];
  logic [TERM_W-1:0] term_a    [NODES];
  logic [CNT_W-1:0]  vote_a    [NODES];
  logic [FILL_W-1:0] fill_a    [NODES];
  logic [FILL_W-1:0] commit_a  [NODES];
  logic [FILL_W-1:0] applied_a [NODES];
  logic [31:0]       count_a   [NODES];
  logic [31:0]       last_a    [NODES];
  logic [TERM_W-1:0] tail_a    [NODES];
  logic [CNT_W-1:0]  leader;

  // Working registers
  logic [3:0]        state;
  logic [1:0]        op_r;
  logic [NODE_W-1:0] n_r;
  logic [31:0]       tok_r;
  logic [1:0]        status;
  logic              elected;
  logic [CNT_W-1:0]  votes;
  logic [POS_W-1:0]  eidx;
  logic [TERM_W-1:0] w_term;
  logic [TERM_W-1:0] w_myterm;
  logic [FILL_W-1:0] w_fill;
  logic [FILL_W-1:0] w_commit;
  logic [FILL_W-1:0] w_applied;
  logic [FILL_W-1:0] fillp;
  logic [CNT_W-1:0]  i;
  logic [FILL_W-1:0] j;
  logic [FILL_W-1:0] fi;
  logic [FILL_W-1:0] k;
  logic [FILL_W-1:0] mcopy [NODES];
  logic [NODES-1:0]  hv;

  // Memory ports
  logic              log_we;
  logic [LOG_AW-1:0] log_waddr;
  slot_word_t        log_wd;
  logic [LOG_AW-1:0] log_raddr;
  slot_word_t        log_rd;
  logic              peer_we;
  logic [PEER_AW-1:0] peer_waddr;
  peer_entry_t       peer_wd;
  logic [PEER_AW-1:0] peer_raddr;
  peer_entry_t       peer_rd;

  // Combinational helpers
  logic [NODE_W-1:0] pi;
  logic [NODE_W-1:0] rd_idx;
  logic [CNT_W-1:0]  maj;
  logic [TERM_W-1:0] term_inc;
  logic              grant;
  logic [NODES-1:0]  hv_next;
  logic [CNT_W-1:0]  hits;
  logic              range_bad;
  logic              win;

  ccle_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(NODES * LOG_DEPTH)) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wd),
    .raddr (log_raddr),
    .rdata (log_rd)
  );

  ccle_ram #(.WIDTH($bits(peer_entry_t)), .DEPTH(NODES * NODES)) u_peer (
    .clk   (clk),
    .we    (peer_we),
    .waddr (peer_waddr),
    .wdata (peer_wd),
    .raddr (peer_raddr),
    .rdata (peer_rd)
  );

  // Decode helpers
  always_comb begin
    pi        = i[NODE_W-1:0];
    rd_idx    = (state == S_LOAD) ? n_r : pi;
    maj       = CNT_W'(cs >> 1) + CNT_W'(1);
    term_inc  = (term_a[n_r] == TERM_MAX) ? term_a[n_r] : term_a[n_r] + TERM_W'(1);
    range_bad = ({1'b0, n_r} >= cs);
    grant     = ((vote_a[rd_idx] == NO_NODE) || (vote_a[rd_idx] == {1'b0, n_r})) &&
                ((w_myterm > tail_a[rd_idx]) ||
                 ((w_myterm == tail_a[rd_idx]) && (w_fill >= fill_a[rd_idx])));
    win       = (votes >= maj);
    for (int x = 0; x < NODES; x++) begin
      hv_next[x] = (mcopy[x] >= k);
    end
    hits = CNT_W'(1);
    for (int x = 0; x < NODES; x++) begin
      hits = hits + CNT_W'(hv[x]);
    end
  end

  // Drive memory ports from the sequencer
  always_comb begin
    log_we     = 1'b0;
    log_waddr  = {n_r, w_fill[POS_W-1:0]};
    log_wd     = '{term: w_term, cmd: 1'b0, token: 32'd0};
    log_raddr  = {n_r, j[POS_W-1:0]};
    peer_we    = 1'b0;
    peer_waddr = {n_r, pi};
    peer_wd    = '{next: w_fill + FILL_W'(1), match: '0};
    peer_raddr = {n_r, pi};
    unique case (state)
      S_LOAD: begin
        log_waddr = {n_r, fill_a[n_r][POS_W-1:0]};
        log_wd    = '{term: term_a[n_r], cmd: 1'b1, token: tok_r};
        log_we    = !range_bad && (op_r == OP_APPEND) &&
                    (role_a[n_r] == ROLE_LEADER) && (fill_a[n_r] < FULL);
      end
      S_EL_PR: begin
        log_we = (i == cs) && win && (w_fill < FULL);
      end
      S_EL_ROW: begin
        peer_we = 1'b1;
      end
      S_AP_CWR: begin
        log_we    = 1'b1;
        log_waddr = {pi, fi[POS_W-1:0]};
        log_wd    = log_rd;
      end
      S_AP_PWR: begin
        peer_we = 1'b1;
        peer_wd = '{next: fillp + FILL_W'(1), match: fillp};
      end
      S_CM_RD: begin
        log_raddr = {n_r, POS_W'(k - FILL_W'(1))};
      end
      S_AY_RD: begin
        log_raddr = {n_r, w_applied[POS_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Sequencer and per-node state
  always_ff @(posedge clk) begin
    if (rst || init) begin
      state  <= S_IDLE;
      leader <= NO_NODE;
      for (int x = 0; x < NODES; x++) begin
        role_a[x]    <= ROLE_FOLLOWER;
        term_a[x]    <= '0;
        vote_a[x]    <= NO_NODE;
        fill_a[x]    <= '0;
        commit_a[x]  <= '0;
        applied_a[x] <= '0;
        count_a[x]   <= '0;
        last_a[x]    <= '0;
        tail_a[x]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= op;
            n_r     <= node;
            tok_r   <= token;
            status  <= ST_OK;
            elected <= 1'b0;
            votes   <= '0;
            eidx    <= '0;
            i       <= '0;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          w_fill    <= fill_a[n_r];
          w_myterm  <= tail_a[n_r];
          w_commit  <= commit_a[n_r];
          w_applied <= applied_a[n_r];
          w_term    <= (op_r == OP_ELECT) ? term_inc : term_a[n_r];
          if (range_bad) begin
            status <= ST_RANGE;
            state  <= S_DONE;
          end else begin
            unique case (op_r)
              OP_ELECT: begin
                term_a[n_r] <= term_inc;
                role_a[n_r] <= ROLE_CANDIDATE;
                vote_a[n_r] <= {1'b0, n_r};
                votes       <= CNT_W'(1);
                state       <= S_EL_PR;
              end
              OP_APPEND: begin
                if (role_a[n_r] != ROLE_LEADER) begin
                  status <= ST_NOLEADER;
                  state  <= S_DONE;
                end else if (fill_a[n_r] >= FULL) begin
                  status <= ST_FULL;
                  state  <= S_DONE;
                end else begin
                  eidx        <= fill_a[n_r][POS_W-1:0];
                  fillp       <= fill_a[n_r] + FILL_W'(1);
                  fill_a[n_r] <= fill_a[n_r] + FILL_W'(1);
                  tail_a[n_r] <= term_a[n_r];
                  state       <= S_AP_PRD;
                end
              end
              OP_COMMIT: begin
                if (role_a[n_r] != ROLE_LEADER) begin
                  status <= ST_NOLEADER;
                  state  <= S_DONE;
                end else begin
                  state <= S_CM_GRD;
                end
              end
              OP_APPLY: begin
                state <= S_AY_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        // Poll one peer per cycle for its vote
        S_EL_PR: begin
          if (i == cs) begin
            i <= '0;
            if (win) begin
              elected     <= 1'b1;
              role_a[n_r] <= ROLE_LEADER;
              leader      <= {1'b0, n_r};
              if (w_fill < FULL) begin
                fill_a[n_r] <= w_fill + FILL_W'(1);
                tail_a[n_r] <= w_term;
              end
              state <= S_EL_ROW;
            end else begin
              state <= S_DONE;
            end
          end else begin
            if ((pi != n_r) && grant) begin
              vote_a[pi] <= {1'b0, n_r};
              votes      <= votes + CNT_W'(1);
            end
            i <= i + CNT_W'(1);
          end
        end
        // Seed the leader's peer row
        S_EL_ROW: begin
          i <= i + CNT_W'(1);
          if (i == LAST_PEER) begin
            state <= S_DONE;
          end
        end
        // Replicate to each follower
        S_AP_PRD: begin
          if (i == cs) begin
            state <= S_DONE;
          end else if (pi == n_r) begin
            i <= i + CNT_W'(1);
          end else begin
            state <= S_AP_PWT;
          end
        end
        S_AP_PWT: begin
          j     <= (peer_rd.next != '0) ? peer_rd.next - FILL_W'(1) : '0;
          fi    <= fill_a[pi];
          state <= S_AP_CRD;
        end
        S_AP_CRD: begin
          if ((j >= fillp) || (fi >= FULL)) begin
            state <= S_AP_PWR;
          end else begin
            state <= S_AP_CWR;
          end
        end
        S_AP_CWR: begin
          fill_a[pi] <= fi + FILL_W'(1);
          tail_a[pi] <= log_rd.term;
          fi         <= fi + FILL_W'(1);
          j          <= j + FILL_W'(1);
          state      <= S_AP_CRD;
        end
        S_AP_PWR: begin
          i     <= i + CNT_W'(1);
          state <= S_AP_PRD;
        end
        // Gather the leader's match indices
        S_CM_GRD: begin
          if (i == CNT_W'(NODES)) begin
            k     <= w_fill;
            state <= S_CM_RD;
          end else begin
            state <= S_CM_GWT;
          end
        end
        S_CM_GWT: begin
          mcopy[pi] <= ((i < cs) && (pi != n_r)) ? peer_rd.match : '0;
          i         <= i + CNT_W'(1);
          state     <= S_CM_GRD;
        end
        // Scan down from the log tail
        S_CM_RD: begin
          if (k <= w_commit) begin
            state <= S_DONE;
          end else begin
            hv    <= hv_next;
            state <= S_CM_CHK;
          end
        end
        S_CM_CHK: begin
          if ((log_rd.term == w_term) && (hits >= maj)) begin
            commit_a[n_r] <= k;
            state         <= S_DONE;
          end else begin
            k     <= k - FILL_W'(1);
            state <= S_CM_RD;
          end
        end
        // Apply one committed entry per pass
        S_AY_RD: begin
          if ((w_applied >= w_commit) || (w_applied >= FULL)) begin
            state <= S_DONE;
          end else begin
            state <= S_AY_UPD;
          end
        end
        S_AY_UPD: begin
          w_applied      <= w_applied + FILL_W'(1);
          applied_a[n_r] <= w_applied + FILL_W'(1);
          if (log_rd.cmd) begin
            count_a[n_r] <= count_a[n_r] + 32'd1;
            last_a[n_r]  <= log_rd.token;
          end
          state <= S_AY_RD;
        end
        S_DONE: begin
          if (!out_hold) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word
  always_comb begin
    idle                     = (state == S_IDLE);
    done                     = (state == S_DONE) && !out_hold;
    res.status               = status;
    res.elected              = elected;
    res.vote_total           = votes;
    res.entry_index          = eidx;
    res.leader_node          = leader;
    if (status == ST_RANGE) begin
      res.commit_point         = '0;
      res.applied_point        = '0;
      res.machine_count        = '0;
      res.last_applied_command = '0;
    end else begin
      res.commit_point         = commit_a[n_r];
      res.applied_point        = applied_a[n_r];
      res.machine_count        = count_a[n_r];
      res.last_applied_command = last_a[n_r];
    end
  end

endmodule

>>> rtl/consensus_cluster_log_engine.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   op, node, command_token
// result    out        out_valid / out_stall status .. leader_node
// config    in         APB psel/penable      cluster_size at paddr 0
//
// One op at a time. Elect polls each node below cluster_size and on a win
// seeds the leader's peer row; append copies to each follower; commit gathers
// match indices and scans down the log; apply walks committed entries; refused
// ops stop at load. The log memory port is the limit: one entry read or written
// per step. Reset and a valid cluster_size write clear node state; no clearing
// pass. A finished word waits in the output register while the next op runs.
module consensus_cluster_log_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [ccle_pkg::NODE_W-1:0]  node,
  input  logic [31:0]                  command_token,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic                         elected,
  output logic [ccle_pkg::CNT_W-1:0]   vote_total,
  output logic [ccle_pkg::POS_W-1:0]   entry_index,
  output logic [ccle_pkg::FILL_W-1:0]  commit_point,
  output logic [ccle_pkg::FILL_W-1:0]  applied_point,
  output logic [31:0]                  machine_count,
  output logic [31:0]                  last_applied_command,
  output logic [ccle_pkg::CNT_W-1:0]   leader_node
);
  import ccle_pkg::*;

  logic [CNT_W-1:0] cluster_size;
  logic             cfg_wr;
  logic             init;
  logic             idle;
  logic             done;
  logic             out_hold;
  res_t             res;
  res_t             out_r;

  // Register write and readback
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign init   = cfg_wr && (pwdata != 32'd0) && (pwdata <= 32'(NODES));
  assign prdata = paddr[2] ? 32'd0 : 32'(cluster_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_size <= CNT_W'(5);
    end else if (init) begin
      cluster_size <= pwdata[CNT_W-1:0];
    end
  end

  assign in_stall = !idle;
  assign out_hold = out_valid && out_stall;

  ccle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .init     (init),
    .cs       (cluster_size),
    .start    (in_valid && idle),
    .op       (op),
    .node     (node),
    .token    (command_token),
    .out_hold (out_hold),
    .idle     (idle),
    .done     (done),
    .res      (res)
  );

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= res;
    end
  end

  assign status               = out_r.status;
  assign elected              = out_r.elected;
  assign vote_total           = out_r.vote_total;
  assign entry_index          = out_r.entry_index;
  assign commit_point         = out_r.commit_point;
  assign applied_point        = out_r.applied_point;
  assign machine_count        = out_r.machine_count;
  assign last_applied_command = out_r.last_applied_command;
  assign leader_node          = out_r.leader_node;

endmodule
